@@ rtl/mtic_pkg.sv @@
`default_nettype none
package mtic_pkg;

   localparam int NTHR   = 8;
   localparam int NREG   = 8;
   localparam int THR_W  = $clog2(NTHR);
   localparam int REG_W  = $clog2(NREG);
   localparam int SLOT_W = THR_W + REG_W;
   localparam int NSLOT  = NTHR * NREG;
   localparam int CNT_W  = $clog2(NTHR + 1);
   localparam int XLEN   = 32;
   localparam int BUSY_W = 9;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_ADDI  = 3'd3,
      OP_SUBI  = 3'd4,
      OP_LOAD  = 3'd5,
      OP_STORE = 3'd6,
      OP_HALT  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CSR_MODE    = 3'd0,
      CSR_THREADS = 3'd1,
      CSR_SWITCH  = 3'd2,
      CSR_LD_LAT  = 3'd3,
      CSR_ST_LAT  = 3'd4
   } csr_idx_type;

   // effective configuration seen by the back end
   typedef struct packed {
      logic             mode;
      logic [CNT_W-1:0] n;
      logic [7:0]       sw_load;
      logic [7:0]       ld_lat;
      logic [7:0]       st_lat;
   } cfg_type;

   typedef struct packed {
      op_type                 op;
      logic [REG_W-1:0]       dst;
      logic [REG_W-1:0]       src1;
      logic signed [XLEN-1:0] imm;
      logic                   use_imm;
      logic signed [XLEN-1:0] ldata;
      logic                   ldvalid;
      logic                   is_mem;
   } item_type;

   typedef struct packed {
      logic                   issued;
      logic                   fetch_valid;
      logic [2:0]             fetch_thread;
      logic [XLEN-1:0]        fetch_pc;
      logic                   mem_read;
      logic                   mem_write;
      logic [XLEN-1:0]        mem_addr;
      logic signed [XLEN-1:0] store_data;
      logic                   all_halted;
      logic [XLEN-1:0]        cycle_total;
      logic [XLEN-1:0]        instr_total;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/mtic_ram.sv @@
`default_nettype none
module mtic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule
`default_nettype wire

@@ rtl/mtic_front.sv @@
`default_nettype none
module mtic_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire mtic_pkg::item_type in_item,
   output logic                   q_valid,
   output mtic_pkg::item_type     q_item,
   input  wire logic              q_pop
);
   import mtic_pkg::*;

   item_type   slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push;
   item_type   cls;

   // classify the beat on the way in
   always_comb begin
      cls        = in_item;
      cls.is_mem = (in_item.op == OP_LOAD) || (in_item.op == OP_STORE);
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= cls;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule
`default_nettype wire

@@ rtl/mtic_back.sv @@
`default_nettype none
module mtic_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mtic_pkg::cfg_type  cfg,
   input  wire logic               q_valid,
   input  wire mtic_pkg::item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mtic_pkg::rsp_type       rsp
);
   import mtic_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_WB, S_RD, S_RD2, S_EX} state_type;

   state_type         state_ff;
   item_type          item_ff;
   logic [THR_W-1:0]  cur_ff;
   logic [7:0]        swcnt_ff;
   logic              just_ff;
   logic              pend_v_ff;
   logic [SLOT_W-1:0] pend_tgt_ff;
   logic [BUSY_W-1:0] busy_ff [NTHR];
   logic [NTHR-1:0]   halt_ff;
   logic [XLEN-1:0]   pc_ff [NTHR];
   logic [XLEN-1:0]   cyc_ff, ins_ff;
   logic [NSLOT-1:0]  vld_ff;
   logic [XLEN-1:0]   opa_ff, opb_ff;
   logic              va_ff, vb_ff;
   rsp_type           rsp_ff;
   logic              rsp_v_ff;

   // first ready thread from start, round-robin over n
   function automatic logic [THR_W-1:0] rr_scan(input logic [NTHR-1:0] rdy,
         input logic [THR_W-1:0] start, input logic [CNT_W-1:0] n,
         input logic [THR_W-1:0] fallback);
      logic [CNT_W:0]   idx;
      logic             found;
      logic [THR_W-1:0] res;
      found = 1'b0;
      res   = fallback;
      for (int k = 0; k < NTHR; k++) begin
         idx = (CNT_W+1)'(start) + (CNT_W+1)'(k);
         if (idx >= {1'b0, n}) idx = idx - {1'b0, n};
         if (!found && ((CNT_W+1)'(k) < {1'b0, n}) && rdy[idx[THR_W-1:0]]) begin
            found = 1'b1;
            res   = idx[THR_W-1:0];
         end
      end
      return res;
   endfunction

   logic [THR_W-1:0]  cur_eff, cur_inc, cur_n, nxt0, nxt1, t;
   logic [NTHR-1:0]   inuse, rdy0, rdy1, halt_n;
   logic [BUSY_W-1:0] busy_n [NTHR];
   logic [XLEN-1:0]   pc_n [NTHR];
   logic              done0, done1, go, fvalid, just_n, out_free, commit;
   logic [7:0]        cnt_n;
   logic [XLEN-1:0]   a, r2, d, off, res_val, addr;
   logic              wr_rd, is_ld, is_st;
   logic              we;
   logic [SLOT_W-1:0] waddr, raddr_a, raddr_b;
   logic [XLEN-1:0]   wdata, rdata_a, rdata_b;

   mtic_ram #(.WIDTH(XLEN), .DEPTH(NSLOT)) u_rf (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
   );

   assign cur_eff  = ({1'b0, cur_ff} >= (THR_W+1)'(cfg.n)) ? '0 : cur_ff;
   assign t        = cur_eff;
   assign out_free = !rsp_v_ff || rsp_ready;
   assign commit   = (state_ff == S_EX) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   // register file ports: operands in S_RD, store base from S_RD2 through execute
   always_comb begin
      raddr_a = {t, item_ff.src1};
      raddr_b = {t, item_ff.imm[REG_W-1:0]};
      if (state_ff == S_RD2 || state_ff == S_EX) raddr_a = {t, item_ff.dst};
   end

   assign a  = opa_ff;
   assign r2 = opb_ff;
   assign d  = va_ff ? rdata_a : '0;
   assign is_ld = go && (item_ff.op == OP_LOAD);
   assign is_st = go && (item_ff.op == OP_STORE);

   // cycle plan, execute and next thread choice
   always_comb begin
      for (int i = 0; i < NTHR; i++) begin
         inuse[i] = (CNT_W'(i) < cfg.n);
         rdy0[i]  = (busy_ff[i] == '0) && !halt_ff[i];
      end
      done0  = &(halt_ff | ~inuse);
      go     = 1'b0;
      cur_n  = cur_eff;
      cnt_n  = swcnt_ff;
      just_n = just_ff;
      nxt0   = rr_scan(rdy0, cur_eff, cfg.n, cur_eff);
      if (!done0) begin
         if (!cfg.mode) begin
            go = rdy0[cur_eff];
         end else if (swcnt_ff != 8'd0) begin
            cnt_n = swcnt_ff - 8'd1;
         end else if (just_ff) begin
            just_n = 1'b0;
            go     = rdy0[cur_eff];
         end else if (nxt0 != cur_eff) begin
            cnt_n  = cfg.sw_load;
            cur_n  = nxt0;
            just_n = 1'b1;
         end else begin
            go = rdy0[cur_eff];
         end
      end

      off     = item_ff.use_imm ? item_ff.imm : r2;
      addr    = '0;
      res_val = '0;
      wr_rd   = 1'b0;
      unique case (item_ff.op)
         OP_ADD:   begin res_val = a + r2;          wr_rd = go; end
         OP_SUB:   begin res_val = a - r2;          wr_rd = go; end
         OP_ADDI:  begin res_val = a + item_ff.imm; wr_rd = go; end
         OP_SUBI:  begin res_val = a - item_ff.imm; wr_rd = go; end
         OP_LOAD:  addr = go ? a + off : '0;
         OP_STORE: addr = go ? d + off : '0;
         OP_NOP, OP_HALT: ;
         default: ;
      endcase

      for (int i = 0; i < NTHR; i++) begin
         busy_n[i] = busy_ff[i];
         if (THR_W'(i) == t && is_ld) busy_n[i] = {1'b0, cfg.ld_lat} + 9'd1;
         if (THR_W'(i) == t && is_st) busy_n[i] = {1'b0, cfg.st_lat} + 9'd1;
         if (!done0 && inuse[i] && busy_n[i] != '0) busy_n[i] = busy_n[i] - 9'd1;
         halt_n[i] = halt_ff[i] || (go && item_ff.op == OP_HALT && THR_W'(i) == t);
         pc_n[i]   = (go && THR_W'(i) == t) ? pc_ff[i] + 32'd1 : pc_ff[i];
         rdy1[i]   = (busy_n[i] == '0) && !halt_n[i];
      end

      cur_inc = ((CNT_W'(cur_eff) + CNT_W'(1)) == cfg.n) ? '0 : cur_eff + THR_W'(1);
      if (!done0 && !cfg.mode) cur_n = rr_scan(rdy1, cur_inc, cfg.n, cur_eff);

      done1  = &(halt_n | ~inuse);
      nxt1   = rr_scan(rdy1, cur_n, cfg.n, cur_n);
      fvalid = 1'b0;
      if (!done1) begin
         if (!cfg.mode)            fvalid = rdy1[cur_n];
         else if (cnt_n != 8'd0)   fvalid = 1'b0;
         else if (just_n)          fvalid = rdy1[cur_n];
         else if (nxt1 != cur_n)   fvalid = 1'b0;
         else                      fvalid = rdy1[cur_n];
      end
   end

   // single write port: load write-back, then result write
   always_comb begin
      we    = 1'b0;
      waddr = pend_tgt_ff;
      wdata = item_ff.ldata;
      if (state_ff == S_WB) begin
         we = pend_v_ff && item_ff.ldvalid;
      end else if (commit) begin
         we    = wr_rd;
         waddr = {t, item_ff.dst};
         wdata = res_val;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cur_ff    <= '0;
         swcnt_ff  <= '0;
         just_ff   <= 1'b1;
         pend_v_ff <= 1'b0;
         halt_ff   <= '0;
         vld_ff    <= '0;
         cyc_ff    <= '0;
         ins_ff    <= '0;
         rsp_v_ff  <= 1'b0;
         for (int i = 0; i < NTHR; i++) begin
            busy_ff[i] <= '0;
            pc_ff[i]   <= '0;
         end
      end else begin
         if (rsp_v_ff && rsp_ready && !commit) rsp_v_ff <= 1'b0;
         if (we) vld_ff[waddr] <= 1'b1;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               pend_v_ff <= 1'b0;
               state_ff  <= S_RD;
            end
            S_RD: begin
               va_ff    <= vld_ff[raddr_a];
               vb_ff    <= vld_ff[raddr_b];
               state_ff <= S_RD2;
            end
            S_RD2: begin
               opa_ff   <= va_ff ? rdata_a : '0;
               opb_ff   <= vb_ff ? rdata_b : '0;
               va_ff    <= vld_ff[raddr_a];
               state_ff <= S_EX;
            end
            S_EX: begin
               if (out_free) begin
                  cur_ff   <= cur_n;
                  swcnt_ff <= cnt_n;
                  just_ff  <= just_n;
                  halt_ff  <= halt_n;
                  for (int i = 0; i < NTHR; i++) begin
                     busy_ff[i] <= busy_n[i];
                     pc_ff[i]   <= pc_n[i];
                  end
                  if (is_ld) begin
                     pend_v_ff   <= 1'b1;
                     pend_tgt_ff <= {t, item_ff.dst};
                  end
                  if (!done0 && cyc_ff != '1) cyc_ff <= cyc_ff + 32'd1;
                  if (go && ins_ff != '1) ins_ff <= ins_ff + 32'd1;
                  rsp_v_ff            <= 1'b1;
                  rsp_ff.issued       <= go;
                  rsp_ff.fetch_valid  <= fvalid;
                  rsp_ff.fetch_thread <= 3'(cur_n);
                  rsp_ff.fetch_pc     <= pc_n[cur_n];
                  rsp_ff.mem_read     <= is_ld;
                  rsp_ff.mem_write    <= is_st;
                  rsp_ff.mem_addr     <= addr;
                  rsp_ff.store_data   <= is_st ? a : '0;
                  rsp_ff.all_halted   <= done1;
                  rsp_ff.cycle_total  <= (!done0 && cyc_ff != '1) ? cyc_ff + 32'd1 : cyc_ff;
                  rsp_ff.instr_total  <= (go && ins_ff != '1) ? ins_ff + 32'd1 : ins_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/multithread_issue_core_top.sv @@
`default_nettype none
// Channel   Direction  Handshake          Beat
// req_      in         req_valid/ready    one machine cycle: instruction and load data
// rsp_      out        rsp_valid/ready    issue, fetch request, memory access, counts
// csr_      in         csr_valid/ready    register index and write data
//
// Each beat passes in turn through the back end: load write-back, two register
// file reads on the shared two-port RAM, then execute into the output register.
// A two-beat queue sits between the front and the back end.
// Reset is synchronous and clears all thread state; the register file
// reads as zero until written through per-entry valid flags.
// A held rsp beat stalls the back end in execute; the queue keeps taking
// beats until both of its slots are full, then req_ready drops.
module multithread_issue_core_top
   import mtic_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [2:0]             req_opcode,
   input  wire logic [2:0]             req_dst_reg,
   input  wire logic [2:0]             req_src1_reg,
   input  wire logic signed [31:0]     req_src2_or_imm,
   input  wire logic                   req_src2_is_imm,
   input  wire logic signed [31:0]     req_load_data,
   input  wire logic                   req_load_data_valid,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_issued,
   output logic                        rsp_fetch_valid,
   output logic [2:0]                  rsp_fetch_thread,
   output logic [31:0]                 rsp_fetch_pc,
   output logic                        rsp_mem_read,
   output logic                        rsp_mem_write,
   output logic [31:0]                 rsp_mem_addr,
   output logic signed [31:0]          rsp_store_data,
   output logic                        rsp_all_halted,
   output logic [31:0]                 rsp_cycle_total,
   output logic [31:0]                 rsp_instr_total,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [7:0]             csr_data
);

   logic       mode_ff;
   logic [3:0] tc_ff;
   logic [7:0] sw_ff, ldl_ff, stl_ff;
   cfg_type    cfg;
   item_type   in_item, q_item;
   logic       q_valid, q_pop;
   rsp_type    rsp;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         tc_ff   <= 4'd1;
         sw_ff   <= 8'd1;
         ldl_ff  <= '0;
         stl_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MODE:    mode_ff <= csr_data[0];
            CSR_THREADS: tc_ff   <= csr_data[3:0];
            CSR_SWITCH:  sw_ff   <= csr_data;
            CSR_LD_LAT:  ldl_ff  <= csr_data;
            CSR_ST_LAT:  stl_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective values: thread count clamped, zero switch acts as one
   always_comb begin
      cfg.mode    = mode_ff;
      cfg.n       = (tc_ff == 4'd0) ? CNT_W'(1) :
                    ({1'b0, tc_ff} > 5'(NTHR)) ? CNT_W'(NTHR) : CNT_W'(tc_ff);
      cfg.sw_load = (sw_ff == 8'd0) ? 8'd0 : sw_ff - 8'd1;
      cfg.ld_lat  = ldl_ff;
      cfg.st_lat  = stl_ff;
   end

   always_comb begin
      in_item.op      = op_type'(req_opcode);
      in_item.dst     = req_dst_reg;
      in_item.src1    = req_src1_reg;
      in_item.imm     = req_src2_or_imm;
      in_item.use_imm = req_src2_is_imm;
      in_item.ldata   = req_load_data;
      in_item.ldvalid = req_load_data_valid;
      in_item.is_mem  = 1'b0;
   end

   mtic_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_item(in_item),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   mtic_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   assign rsp_issued       = rsp.issued;
   assign rsp_fetch_valid  = rsp.fetch_valid;
   assign rsp_fetch_thread = rsp.fetch_thread;
   assign rsp_fetch_pc     = rsp.fetch_pc;
   assign rsp_mem_read     = rsp.mem_read;
   assign rsp_mem_write    = rsp.mem_write;
   assign rsp_mem_addr     = rsp.mem_addr;
   assign rsp_store_data   = rsp.store_data;
   assign rsp_all_halted   = rsp.all_halted;
   assign rsp_cycle_total  = rsp.cycle_total;
   assign rsp_instr_total  = rsp.instr_total;

   // a memory access always comes from an issued instruction
   a_mem_issued: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mem_read || rsp_mem_write)) |-> rsp_issued)
      else $error("memory access without issue");

   // at most one memory access per beat
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_mem_read && rsp_mem_write))
      else $error("load and store in one beat");

   // no access means zero address and zero store data
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mem_read && !rsp_mem_write) |->
      (rsp_mem_addr == 32'd0 && rsp_store_data == 32'sd0))
      else $error("stale memory fields");

endmodule
`default_nettype wire

@@ sim/mtic_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
// Watches the request, response and register channels of the issue core,
// runs a cycle model of the core for every accepted request beat and
// compares each response beat with the oldest prediction.
module mtic_checker
   import mtic_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [2:0]         req_dst_reg,
   input  wire logic [2:0]         req_src1_reg,
   input  wire logic signed [31:0] req_src2_or_imm,
   input  wire logic               req_src2_is_imm,
   input  wire logic signed [31:0] req_load_data,
   input  wire logic               req_load_data_valid,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_issued,
   input  wire logic               rsp_fetch_valid,
   input  wire logic [2:0]         rsp_fetch_thread,
   input  wire logic [31:0]        rsp_fetch_pc,
   input  wire logic               rsp_mem_read,
   input  wire logic               rsp_mem_write,
   input  wire logic [31:0]        rsp_mem_addr,
   input  wire logic signed [31:0] rsp_store_data,
   input  wire logic               rsp_all_halted,
   input  wire logic [31:0]        rsp_cycle_total,
   input  wire logic [31:0]        rsp_instr_total,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_data,
   output int                      fail_count,
   output int                      outstanding
);

   // configuration copy
   logic       mode_blocked;
   logic [3:0] thr_cfg;
   logic [7:0] sw_cfg;
   logic [7:0] ld_lat;
   logic [7:0] st_lat;

   // core state copy
   logic [31:0] regfile [NSLOT];
   logic [31:0] pc_of [NTHR];
   int unsigned busy_of [NTHR];
   logic        halted_of [NTHR];
   int unsigned cur_thr;
   int unsigned sw_left;
   logic        sw_fresh;
   logic        ld_pend;
   int unsigned ld_slot;
   logic [31:0] cyc_cnt;
   logic [31:0] ins_cnt;

   rsp_type expected_beats [$];

   function automatic logic thr_ready(int unsigned t);
      return busy_of[t] == 0 && !halted_of[t];
   endfunction

   function automatic logic all_stopped(int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         if (!halted_of[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned next_ready(int unsigned start, int unsigned n,
                                              int unsigned fallback);
      int unsigned i;
      for (int unsigned k = 0; k < n; k++) begin
         i = (start + k) % n;
         if (thr_ready(i)) return i;
      end
      return fallback;
   endfunction

   // may the current thread issue; commit advances the switch sequencer
   function automatic logic may_issue(logic commit, int unsigned n);
      int unsigned nxt;
      if (!mode_blocked) return thr_ready(cur_thr);
      if (sw_left > 0) begin
         if (commit) sw_left--;
         return 1'b0;
      end
      if (sw_fresh) begin
         if (commit) sw_fresh = 1'b0;
         return thr_ready(cur_thr);
      end
      nxt = next_ready(cur_thr, n, cur_thr);
      if (nxt != cur_thr) begin
         if (commit) begin
            sw_left  = ((sw_cfg == 0) ? 1 : sw_cfg) - 1;
            cur_thr  = nxt;
            sw_fresh = 1'b1;
         end
         return 1'b0;
      end
      return thr_ready(cur_thr);
   endfunction

   function automatic rsp_type run_cycle(op_type op, logic [2:0] rd, logic [2:0] rs1,
                                         logic [31:0] imm, logic use_imm,
                                         logic [31:0] ldata, logic ldvalid);
      rsp_type     e;
      int unsigned n, t;
      logic [31:0] a, r2;
      e = '0;
      n = (thr_cfg == 0) ? 1 : (thr_cfg > NTHR) ? NTHR : thr_cfg;
      if (cur_thr >= n) cur_thr = 0;
      // load write-back comes first
      if (ld_pend) begin
         if (ldvalid) regfile[ld_slot] = ldata;
         ld_pend = 1'b0;
      end
      if (!all_stopped(n)) begin
         if (may_issue(1'b1, n)) begin
            t  = cur_thr;
            a  = regfile[t*NREG + rs1];
            r2 = regfile[t*NREG + imm[2:0]];
            e.issued = 1'b1;
            case (op)
               OP_ADD:  regfile[t*NREG + rd] = a + r2;
               OP_SUB:  regfile[t*NREG + rd] = a - r2;
               OP_ADDI: regfile[t*NREG + rd] = a + imm;
               OP_SUBI: regfile[t*NREG + rd] = a - imm;
               OP_LOAD: begin
                  e.mem_addr = a + (use_imm ? imm : r2);
                  e.mem_read = 1'b1;
                  ld_pend    = 1'b1;
                  ld_slot    = t*NREG + rd;
                  busy_of[t] = ld_lat + 1;
               end
               OP_STORE: begin
                  e.mem_addr   = regfile[t*NREG + rd] + (use_imm ? imm : r2);
                  e.store_data = a;
                  e.mem_write  = 1'b1;
                  busy_of[t]   = st_lat + 1;
               end
               OP_HALT: halted_of[t] = 1'b1;
               default: ;
            endcase
            pc_of[t]++;
            if (ins_cnt != '1) ins_cnt++;
         end
         for (int unsigned i = 0; i < n; i++)
            if (busy_of[i] > 0) busy_of[i]--;
         if (!mode_blocked) cur_thr = next_ready((cur_thr + 1) % n, n, cur_thr);
         if (cyc_cnt != '1) cyc_cnt++;
      end
      e.all_halted   = all_stopped(n);
      e.fetch_valid  = e.all_halted ? 1'b0 : may_issue(1'b0, n);
      e.fetch_thread = cur_thr[2:0];
      e.fetch_pc     = pc_of[cur_thr];
      e.cycle_total  = cyc_cnt;
      e.instr_total  = ins_cnt;
      return e;
   endfunction

   function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         mode_blocked = 1'b0;
         thr_cfg      = 4'd1;
         sw_cfg       = 8'd1;
         ld_lat       = 8'd0;
         st_lat       = 8'd0;
         for (int i = 0; i < NSLOT; i++) regfile[i] = '0;
         for (int i = 0; i < NTHR; i++) begin
            pc_of[i]     = '0;
            busy_of[i]   = 0;
            halted_of[i] = 1'b0;
         end
         cur_thr  = 0;
         sw_left  = 0;
         sw_fresh = 1'b1;
         ld_pend  = 1'b0;
         ld_slot  = 0;
         cyc_cnt  = '0;
         ins_cnt  = '0;
         expected_beats.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_MODE:    mode_blocked = csr_data[0];
               CSR_THREADS: thr_cfg      = csr_data[3:0];
               CSR_SWITCH:  sw_cfg       = csr_data;
               CSR_LD_LAT:  ld_lat       = csr_data;
               CSR_ST_LAT:  st_lat       = csr_data;
               default: ;
            endcase
         end
         // one machine cycle per request beat
         if (req_valid && req_ready)
            expected_beats.push_back(run_cycle(op_type'(req_opcode), req_dst_reg,
               req_src1_reg, req_src2_or_imm, req_src2_is_imm, req_load_data,
               req_load_data_valid));
         // response beat against oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: response beat with nothing expected", $time);
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               cmp_field("issued", e.issued, rsp_issued);
               cmp_field("fetch_valid", e.fetch_valid, rsp_fetch_valid);
               cmp_field("fetch_thread", e.fetch_thread, rsp_fetch_thread);
               cmp_field("fetch_pc", e.fetch_pc, rsp_fetch_pc);
               cmp_field("mem_read", e.mem_read, rsp_mem_read);
               cmp_field("mem_write", e.mem_write, rsp_mem_write);
               cmp_field("mem_addr", e.mem_addr, rsp_mem_addr);
               cmp_field("store_data", e.store_data, rsp_store_data);
               cmp_field("all_halted", e.all_halted, rsp_all_halted);
               cmp_field("cycle_total", e.cycle_total, rsp_cycle_total);
               cmp_field("instr_total", e.instr_total, rsp_instr_total);
            end
         end
      end
      outstanding <= expected_beats.size();
   end

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import mtic_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_opcode = '0;
   logic [2:0]         req_dst_reg = '0;
   logic [2:0]         req_src1_reg = '0;
   logic signed [31:0] req_src2_or_imm = '0;
   logic               req_src2_is_imm = 1'b0;
   logic signed [31:0] req_load_data = '0;
   logic               req_load_data_valid = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_issued, rsp_fetch_valid, rsp_mem_read, rsp_mem_write;
   logic               rsp_all_halted;
   logic [2:0]         rsp_fetch_thread;
   logic [31:0]        rsp_fetch_pc, rsp_mem_addr, rsp_cycle_total, rsp_instr_total;
   logic signed [31:0] rsp_store_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [7:0]         csr_data = '0;
   int                 fail_count, outstanding;

   int  beats_sent = 0;
   int  burst_left = 0;
   bit  hold_kick = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   multithread_issue_core_top dut (.*);

   mtic_checker chk (.*);

   // response side: random stall styles, plus one long hold on request
   initial begin
      int  hold_left;
      int  style;
      bit  hold_seen;
      hold_left = 0;
      style     = 0;
      hold_seen = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = 120;
         end
         if ($urandom_range(0, 47) == 0) style = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // one request beat, sent in bursts with random gaps
   task automatic send_beat(op_type op, logic [2:0] rd, logic [2:0] rs1,
                            logic [31:0] imm, logic use_imm, logic [31:0] ldata,
                            logic ldvalid);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_dst_reg         <= rd;
      req_src1_reg        <= rs1;
      req_src2_or_imm     <= imm;
      req_src2_is_imm     <= use_imm;
      req_load_data       <= ldata;
      req_load_data_valid <= ldvalid;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (outstanding != 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_mode(logic blk, logic [7:0] thr, logic [7:0] sw,
                           logic [7:0] ldl, logic [7:0] stl);
      write_reg(CSR_MODE, {7'd0, blk});
      write_reg(CSR_THREADS, thr);
      write_reg(CSR_SWITCH, sw);
      write_reg(CSR_LD_LAT, ldl);
      write_reg(CSR_ST_LAT, stl);
   endtask

   // random instruction mix; halts only when allowed
   task automatic random_beats(int count, bit with_halt);
      op_type      op;
      logic [31:0] imm;
      for (int i = 0; i < count; i++) begin
         if (with_halt && $urandom_range(0, 9) == 0) op = OP_HALT;
         else op = op_type'($urandom_range(0, 6));
         imm = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
         send_beat(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), imm,
                   1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 7) != 0);
      end
   endtask

   initial begin
      #4000000;
      $display("multithread_issue_core_top: mismatch");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, single thread, fine-grained
      send_beat(OP_ADDI, 3'd1, 3'd0, 32'h7fffffff, 1'b0, '0, 1'b0);
      send_beat(OP_SUBI, 3'd2, 3'd0, 32'h80000000, 1'b0, '0, 1'b0);
      send_beat(OP_ADD,  3'd7, 3'd1, 32'hfffffffa, 1'b0, '0, 1'b1);
      send_beat(OP_SUB,  3'd3, 3'd7, 32'h7fffffff, 1'b0, 32'hffffffff, 1'b1);
      send_beat(OP_NOP,  3'd0, 3'd0, 32'hffffffff, 1'b1, 32'h12345678, 1'b1);
      send_beat(OP_LOAD, 3'd4, 3'd1, 32'hffffffff, 1'b1, '0, 1'b0);
      send_beat(OP_NOP,  3'd0, 3'd0, '0, 1'b0, 32'hdeadbeef, 1'b1);
      send_beat(OP_LOAD, 3'd5, 3'd2, 32'd9, 1'b0, '0, 1'b0);
      send_beat(OP_NOP,  3'd0, 3'd0, '0, 1'b0, 32'h80000000, 1'b0);
      send_beat(OP_STORE, 3'd7, 3'd4, 32'h00000001, 1'b1, '0, 1'b0);
      send_beat(OP_STORE, 3'd1, 3'd7, 32'h0000000f, 1'b0, '0, 1'b0);
      send_beat(OP_ADDI, 3'd6, 3'd5, 32'hffffffff, 1'b0, 32'hffffffff, 1'b1);
      send_beat(OP_ADD,  3'd6, 3'd6, 32'd6, 1'b0, '0, 1'b0);
      drain();

      // fine-grained, all threads; one long response hold while sending
      set_mode(1'b0, 8'd8, 8'd1, 8'd3, 8'd0);
      hold_kick = ~hold_kick;
      random_beats(100, 1'b0);
      drain();

      set_mode(1'b1, 8'd4, 8'd3, 8'd2, 8'd5);
      random_beats(100, 1'b0);
      drain();

      // latency and switch extremes
      set_mode(1'b1, 8'd2, 8'd255, 8'd255, 8'd255);
      random_beats(60, 1'b0);
      drain();

      // thread count above range, switch setting of zero
      set_mode(1'b0, 8'd15, 8'd0, 8'd0, 8'd255);
      random_beats(80, 1'b0);
      drain();

      // thread count of zero
      set_mode(1'b1, 8'd0, 8'd0, 8'd1, 8'd1);
      random_beats(60, 1'b0);
      drain();

      // all threads, halts allowed until the core stops
      set_mode(1'b1, 8'd8, 8'd7, 8'd10, 8'd2);
      random_beats(100, 1'b1);
      drain();

      $display("Ran %0d request beats over fine-grained and blocked modes,", beats_sent);
      $display("thread counts 0..15, latency and switch extremes, up to full halt.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("multithread_issue_core_top: match");
      end else begin
         $display("multithread_issue_core_top: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
